>>> sv/lru_idle_timeout_list_macros.svh
// Assertion macros used by the checker of the idle-timeout list.
// No dependencies; included by files that hold concurrent assertions.
`ifndef LRU_IDLE_TIMEOUT_LIST_MACROS_SVH
`define LRU_IDLE_TIMEOUT_LIST_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define LTL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define LTL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/ltl_pkg.sv
// Shared types and constants of the idle-timeout list.
// No dependencies; used by every module of the block.
package ltl_pkg;

    localparam int ENTRIES = 4096;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = IDX_W + 1;
    localparam int TIME_W  = 32;
    localparam int TMO_W   = 24;
    localparam int ID_W    = 12;
    localparam int DATA_W  = 40;

    localparam logic [TMO_W-1:0] REMAIN_MAX = {TMO_W{1'b1}};

    localparam logic [1:0] OP_ARM  = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_POLL = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_EXPIRED = 2'd1;
    localparam logic [1:0] ST_PENDING = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    typedef enum logic [1:0] {
        K_ARM,
        K_TICK,
        K_POLL,
        K_NOP
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic [ID_W-1:0]  id;
        logic [TMO_W-1:0] tmo;
    } qentry_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ARM_EV,
        S_ARM_MOVE,
        S_POLL_EV
    } state_t;

endpackage

>>> sv/lru_idle_timeout_list.sv
// A tick, no-op or empty poll is written straight to the result register; a poll passes
// S_POLL_EV, an arm S_ARM_EV, and the move of a live id S_ARM_EV and then S_ARM_MOVE.
// The list engine handles one request at a time; it takes the next only when idle and the
// result register is free.
// After reset a clearing pass over every entry empties the valid map; no request is
// taken during it. Clock, head, tail and count reset to zero.
module lru_idle_timeout_list (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // operation[1:0], id[13:2], timeout[37:14], zero[39:38]
    input  logic [ltl_pkg::DATA_W-1:0] s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // status[1:0], expired_id[13:2], remaining_ms[37:14], zero[39:38]
    output logic [ltl_pkg::DATA_W-1:0] m_axis_tdata
);

    ltl_pkg::qentry_t          push_entry;
    ltl_pkg::qentry_t          head_entry;
    logic                      q_push, q_pop, q_full, q_not_empty, back_ready;
    logic [1:0]                status;
    logic [ltl_pkg::ID_W-1:0]  expired_id;
    logic [ltl_pkg::TMO_W-1:0] remaining_ms;

    ltl_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_full        (q_full),
        .back_ready    (back_ready),
        .q_push        (q_push),
        .q_entry       (push_entry)
    );

    ltl_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_entry),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_data (head_entry)
    );

    ltl_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_not_empty),
        .q_data     (head_entry),
        .q_pop      (q_pop),
        .ready      (back_ready),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (status),
        .out_id     (expired_id),
        .out_remain (remaining_ms)
    );

    assign m_axis_tdata = {2'b00, remaining_ms, expired_id, status};

endmodule

>>> sv/ltl_front.sv
// Front end: takes input requests and classifies them for the queue.
// Depends on ltl_pkg.
module ltl_front (
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [ltl_pkg::DATA_W-1:0] s_axis_tdata,
    input  logic                       q_full,
    input  logic                       back_ready,
    output logic                       q_push,
    output ltl_pkg::qentry_t           q_entry
);

    logic [1:0] op;

    assign op            = s_axis_tdata[1:0];
    assign s_axis_tready = !q_full && back_ready;
    assign q_push        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        q_entry.id  = s_axis_tdata[13:2];
        q_entry.tmo = s_axis_tdata[37:14];
        case (op)
            ltl_pkg::OP_ARM:  q_entry.kind = ltl_pkg::K_ARM;
            ltl_pkg::OP_TICK: q_entry.kind = ltl_pkg::K_TICK;
            ltl_pkg::OP_POLL: q_entry.kind = ltl_pkg::K_POLL;
            default:          q_entry.kind = ltl_pkg::K_NOP;
        endcase
    end

endmodule

>>> sv/ltl_fifo.sv
// Two-entry queue between the front end and the list engine.
// Depends on ltl_pkg.
module ltl_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ltl_pkg::qentry_t push_data,
    input  logic             pop,
    output logic             full,
    output logic             not_empty,
    output ltl_pkg::qentry_t head_data
);

    ltl_pkg::qentry_t slot_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> sv/ltl_back.sv
// List engine: linked-list memories, clock counter and the result register.
// Depends on ltl_pkg.
module ltl_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    input  ltl_pkg::qentry_t          q_data,
    output logic                      q_pop,
    output logic                      ready,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [1:0]                out_status,
    output logic [ltl_pkg::ID_W-1:0]  out_id,
    output logic [ltl_pkg::TMO_W-1:0] out_remain
);

    localparam int IW = ltl_pkg::IDX_W;
    localparam int CW = ltl_pkg::CNT_W;
    localparam int TW = ltl_pkg::TIME_W;

    ltl_pkg::state_t state_reg, state_next;
    logic [TW-1:0]   time_reg, time_next;
    logic [IW-1:0]   head_reg, head_next;
    logic [IW-1:0]   tail_reg, tail_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [IW-1:0]   clr_reg, clr_next;
    logic [IW-1:0]   id_reg, id_next;

    logic                      out_valid_reg, out_valid_next;
    logic [1:0]                out_status_reg, out_status_next;
    logic [ltl_pkg::ID_W-1:0]  out_id_reg, out_id_next;
    logic [ltl_pkg::TMO_W-1:0] out_remain_reg, out_remain_next;

    logic          valid_mem  [ltl_pkg::ENTRIES];
    logic [TW-1:0] expiry_mem [ltl_pkg::ENTRIES];
    logic [IW-1:0] prev_mem   [ltl_pkg::ENTRIES];
    logic [IW-1:0] next_mem   [ltl_pkg::ENTRIES];

    logic          valid_rd;
    logic [TW-1:0] expiry_rd;
    logic [IW-1:0] prev_rd;
    logic [IW-1:0] next_rd;
    logic [IW-1:0] rd_addr;

    logic          vw_en, vw_data;
    logic [IW-1:0] vw_addr;
    logic          ew_en;
    logic [IW-1:0] ew_addr;
    logic [TW-1:0] ew_data;
    logic          pw_en;
    logic [IW-1:0] pw_addr, pw_data;
    logic          nw_en;
    logic [IW-1:0] nw_addr, nw_data;

    logic                      res_en;
    logic [1:0]                res_status;
    logic [ltl_pkg::ID_W-1:0]  res_id;
    logic [ltl_pkg::TMO_W-1:0] res_remain;

    logic          out_free;
    logic          start;
    logic [TW-1:0] diff;
    logic          expired;

    // A request starts only when the result register will be free by its end.
    assign out_free = !out_valid_reg || out_ready;
    assign start    = (state_reg == ltl_pkg::S_IDLE) && q_valid && out_free;
    assign q_pop    = start;
    assign ready    = (state_reg != ltl_pkg::S_CLEAR);
    assign rd_addr  = (q_data.kind == ltl_pkg::K_ARM) ? q_data.id[IW-1:0] : head_reg;

    // Wrap-aware compare: expired when the signed difference is zero or negative.
    assign diff    = expiry_rd - time_reg;
    assign expired = (diff == '0) || diff[TW-1];

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_id     = out_id_reg;
    assign out_remain = out_remain_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ltl_pkg::S_CLEAR:
            begin
                if (clr_reg == IW'(ltl_pkg::ENTRIES - 1))
                begin
                    state_next = ltl_pkg::S_IDLE;
                end
            end
            ltl_pkg::S_IDLE:
            begin
                if (start)
                begin
                    if (q_data.kind == ltl_pkg::K_ARM)
                    begin
                        state_next = ltl_pkg::S_ARM_EV;
                    end
                    else if (q_data.kind == ltl_pkg::K_POLL && count_reg != '0)
                    begin
                        state_next = ltl_pkg::S_POLL_EV;
                    end
                end
            end
            ltl_pkg::S_ARM_EV:
            begin
                if (valid_rd && id_reg != tail_reg)
                begin
                    state_next = ltl_pkg::S_ARM_MOVE;
                end
                else
                begin
                    state_next = ltl_pkg::S_IDLE;
                end
            end
            ltl_pkg::S_ARM_MOVE: state_next = ltl_pkg::S_IDLE;
            ltl_pkg::S_POLL_EV:  state_next = ltl_pkg::S_IDLE;
            default:             state_next = ltl_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        time_next  = time_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        clr_next   = clr_reg;
        id_next    = id_reg;
        vw_en      = 1'b0;
        vw_addr    = id_reg;
        vw_data    = 1'b0;
        ew_en      = 1'b0;
        ew_addr    = q_data.id[IW-1:0];
        ew_data    = time_reg + TW'(q_data.tmo);
        pw_en      = 1'b0;
        pw_addr    = id_reg;
        pw_data    = tail_reg;
        nw_en      = 1'b0;
        nw_addr    = tail_reg;
        nw_data    = id_reg;
        res_en     = 1'b0;
        res_status = ltl_pkg::ST_DONE;
        res_id     = '0;
        res_remain = '0;
        case (state_reg)
            ltl_pkg::S_CLEAR:
            begin
                vw_en    = 1'b1;
                vw_addr  = clr_reg;
                clr_next = clr_reg + 1'b1;
            end
            ltl_pkg::S_IDLE:
            begin
                if (start)
                begin
                    case (q_data.kind)
                        ltl_pkg::K_ARM:
                        begin
                            ew_en   = 1'b1;
                            id_next = q_data.id[IW-1:0];
                        end
                        ltl_pkg::K_TICK:
                        begin
                            time_next = time_reg + 1'b1;
                            res_en    = 1'b1;
                        end
                        ltl_pkg::K_POLL:
                        begin
                            if (count_reg == '0)
                            begin
                                res_en     = 1'b1;
                                res_status = ltl_pkg::ST_EMPTY;
                            end
                        end
                        default: res_en = 1'b1;
                    endcase
                end
            end
            ltl_pkg::S_ARM_EV:
            begin
                if (!valid_rd)
                begin
                    // New id goes to the tail.
                    vw_en   = 1'b1;
                    vw_data = 1'b1;
                    pw_en   = 1'b1;
                    if (count_reg != '0)
                    begin
                        nw_en = 1'b1;
                    end
                    else
                    begin
                        head_next = id_reg;
                    end
                    tail_next  = id_reg;
                    count_next = count_reg + 1'b1;
                    res_en     = 1'b1;
                end
                else if (id_reg == tail_reg)
                begin
                    res_en = 1'b1;
                end
                else
                begin
                    // Unlink the live id; it is relinked at the tail next cycle.
                    if (id_reg == head_reg)
                    begin
                        head_next = next_rd;
                    end
                    else
                    begin
                        nw_en   = 1'b1;
                        nw_addr = prev_rd;
                        nw_data = next_rd;
                    end
                    pw_en   = 1'b1;
                    pw_addr = next_rd;
                    pw_data = prev_rd;
                end
            end
            ltl_pkg::S_ARM_MOVE:
            begin
                nw_en     = 1'b1;
                pw_en     = 1'b1;
                tail_next = id_reg;
                res_en    = 1'b1;
            end
            ltl_pkg::S_POLL_EV:
            begin
                res_en = 1'b1;
                if (expired)
                begin
                    vw_en      = 1'b1;
                    vw_addr    = head_reg;
                    count_next = count_reg - 1'b1;
                    if (count_reg == CW'(1))
                    begin
                        head_next = '0;
                        tail_next = '0;
                    end
                    else
                    begin
                        head_next = next_rd;
                        pw_en     = 1'b1;
                        pw_addr   = next_rd;
                        pw_data   = prev_rd;
                    end
                    res_status = ltl_pkg::ST_EXPIRED;
                    res_id     = ltl_pkg::ID_W'(head_reg);
                end
                else
                begin
                    res_status = ltl_pkg::ST_PENDING;
                    res_remain = (diff[TW-1:ltl_pkg::TMO_W] != '0) ? ltl_pkg::REMAIN_MAX
                                                                 : diff[ltl_pkg::TMO_W-1:0];
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_remain_next = out_remain_reg;
        if (res_en)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status;
            out_id_next     = res_id;
            out_remain_next = res_remain;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (vw_en)
        begin
            valid_mem[vw_addr] <= vw_data;
        end
        valid_rd <= valid_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ew_en)
        begin
            expiry_mem[ew_addr] <= ew_data;
        end
        expiry_rd <= expiry_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (pw_en)
        begin
            prev_mem[pw_addr] <= pw_data;
        end
        prev_rd <= prev_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (nw_en)
        begin
            next_mem[nw_addr] <= nw_data;
        end
        next_rd <= next_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        id_reg         <= id_next;
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_remain_reg <= out_remain_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ltl_pkg::S_CLEAR;
            time_reg      <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            time_reg      <= time_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> sv/ltl_checker.sv
// Port-level checker for the idle-timeout list, bound to the top level.
// Depends on ltl_pkg and lru_idle_timeout_list_macros.svh.
`include "lru_idle_timeout_list_macros.svh"

module ltl_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_axis_tvalid,
    input logic                       s_axis_tready,
    input logic [ltl_pkg::DATA_W-1:0] s_axis_tdata,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [ltl_pkg::DATA_W-1:0] m_axis_tdata
);

    logic [1:0] status;

    assign status = m_axis_tdata[1:0];

    `LTL_ASSERT_NXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // Only an expiry carries an id, only a pending head carries a time left, and the pad bits stay zero.
    `LTL_ASSERT_IMP(a_fields, clk, rst_n, m_axis_tvalid,
        ((status == ltl_pkg::ST_EXPIRED) || (m_axis_tdata[13:2] == '0)) &&
        ((status == ltl_pkg::ST_PENDING) || (m_axis_tdata[37:14] == '0)) &&
        (m_axis_tdata[39:38] == '0), "result field set for wrong status")

    `LTL_ASSERT_IMP(a_pending, clk, rst_n, m_axis_tvalid && status == ltl_pkg::ST_PENDING,
        m_axis_tdata[37:14] != '0, "pending head reported with no time left")

endmodule

bind lru_idle_timeout_list ltl_checker u_ltl_checker (.*);

>>> sim/tb_lru_idle_timeout_list.sv
// Testbench of the idle-timeout list: directed and random arm, tick and poll requests.
// Depends on ltl_pkg and lru_idle_timeout_list; a small scoreboard class predicts results.
module tb_lru_idle_timeout_list;

    localparam int LIMIT = 400000;

    logic                        clk;
    logic                        rst_n;
    logic                        s_axis_tvalid;
    logic                        s_axis_tready;
    logic [ltl_pkg::DATA_W-1:0]  s_axis_tdata;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [ltl_pkg::DATA_W-1:0]  m_axis_tdata;

    int errors;
    int cycles = 0;
    int sent;
    int got;
    int busy_ids = 0;

    typedef struct packed {
        logic [1:0]                status;
        logic [ltl_pkg::ID_W-1:0]  exp_id;
        logic [ltl_pkg::TMO_W-1:0] remain;
    } answer_t;

    task automatic report(input string what, input answer_t want, input answer_t seen);
        errors++;
        $display("error %s: want status %0d id %0d rem %0d, got status %0d id %0d rem %0d",
            what, want.status, want.exp_id, want.remain, seen.status, seen.exp_id, seen.remain);
    endtask

    class timeout_board;
        logic [ltl_pkg::TIME_W-1:0] now;
        bit                         live [ltl_pkg::ENTRIES];
        logic [ltl_pkg::TIME_W-1:0] expiry [ltl_pkg::ENTRIES];
        int                         order [$];
        answer_t                    pending [$];

        function new();
            now = '0;
            foreach (live[i]) live[i] = 1'b0;
        endfunction

        function void note_request(input logic [1:0] op, input logic [ltl_pkg::ID_W-1:0] id,
                                   input logic [ltl_pkg::TMO_W-1:0] tmo);
            answer_t a;
            logic [ltl_pkg::TIME_W-1:0] d;
            int h;
            int pos [$];
            a = '0;
            a.status = ltl_pkg::ST_DONE;
            if (op == ltl_pkg::OP_ARM) begin
                expiry[id] = now + ltl_pkg::TIME_W'(tmo);
                if (live[id]) begin
                    pos = order.find_first_index(x) with (x == id);
                    order.delete(pos[0]);
                end
                live[id] = 1'b1;
                order.insert(order.size(), id);
            end else if (op == ltl_pkg::OP_TICK) begin
                now = now + 1;
            end else if (op == ltl_pkg::OP_POLL) begin
                if (order.size() == 0) begin
                    a.status = ltl_pkg::ST_EMPTY;
                end else begin
                    h = order[0];
                    d = expiry[h] - now;
                    if (d == 0 || d[ltl_pkg::TIME_W-1]) begin
                        order.delete(0);
                        live[h] = 1'b0;
                        a.status = ltl_pkg::ST_EXPIRED;
                        a.exp_id = ltl_pkg::ID_W'(h);
                    end else begin
                        a.status = ltl_pkg::ST_PENDING;
                        a.remain = (d > ltl_pkg::TIME_W'(ltl_pkg::REMAIN_MAX)) ?
                                   ltl_pkg::REMAIN_MAX : d[ltl_pkg::TMO_W-1:0];
                    end
                end
            end
            pending.insert(pending.size(), a);
        endfunction

        task check_result(input logic [ltl_pkg::DATA_W-1:0] data);
            answer_t seen;
            answer_t want;
            seen = '{data[1:0], data[13:2], data[37:14]};
            if (pending.size() == 0) begin
                report("unexpected result", '0, seen);
            end else begin
                want = pending[0];
                pending.delete(0);
                if (seen.status != want.status) report("status", want, seen);
                else if (seen.exp_id != want.exp_id) report("expired_id", want, seen);
                else if (seen.remain != want.remain) report("remaining_ms", want, seen);
                else if (data[39:38] != 2'b00) report("pad bits", want, seen);
            end
        endtask
    endclass

    timeout_board board;

    lru_idle_timeout_list i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sends one request and holds it until the handshake; the gap follows.
    task automatic send_request(input logic [1:0] op, input logic [ltl_pkg::ID_W-1:0] id,
                                input logic [ltl_pkg::TMO_W-1:0] tmo, input int gap);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, tmo, id, op};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        board.note_request(op, id, tmo);
        sent++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [ltl_pkg::ID_W-1:0] pick_id();
        // A small pool makes refreshes and expiries frequent; sometimes any id.
        if ($urandom_range(0, 9) == 0) return ltl_pkg::ID_W'($urandom());
        return ltl_pkg::ID_W'($urandom_range(0, 15));
    endfunction

    function automatic logic [ltl_pkg::TMO_W-1:0] pick_tmo();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return ltl_pkg::TMO_W'($urandom_range(0, 12));
        if (r < 8) return ltl_pkg::TMO_W'($urandom_range(0, 200));
        return ltl_pkg::TMO_W'($urandom());
    endfunction

    task automatic random_phase(input int count, input bit calm);
        int r;
        logic [1:0] op;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            op = (r < 40) ? ltl_pkg::OP_ARM : (r < 70) ? ltl_pkg::OP_TICK :
                 (r < 97) ? ltl_pkg::OP_POLL : 2'd3;
            send_request(op, pick_id(), pick_tmo(), calm ? 0 : gap_len());
        end
    endtask

    // The result side stalls at random, with quiet stretches of full readiness.
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready) begin
            board.check_result(m_axis_tdata);
            got++;
        end
        if (busy_ids > 0) begin
            busy_ids <= busy_ids - 1;
            m_axis_tready <= 1'b1;
        end else if ($urandom_range(0, 199) == 0) begin
            busy_ids <= $urandom_range(20, 120);
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) < 70) ||
                             ($urandom_range(0, 99) < 5 ? 1'b0 : 1'b0);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        board = new();
        errors = 0;
        sent = 0;
        got = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty poll, extremes of every field, refresh of tail and head,
        // large remaining time, unused operation, expiry at the exact instant.
        send_request(ltl_pkg::OP_POLL, '0, '0, 0);
        send_request(2'd3, '1, '1, 1);
        send_request(ltl_pkg::OP_ARM, 12'd0, '1, 0);
        send_request(ltl_pkg::OP_POLL, '0, '0, 0);
        send_request(ltl_pkg::OP_ARM, 12'hFFF, 24'd2, 0);
        send_request(ltl_pkg::OP_ARM, 12'd5, 24'd0, 0);
        send_request(ltl_pkg::OP_ARM, 12'd5, 24'd1, 0);
        send_request(ltl_pkg::OP_ARM, 12'd0, 24'd3, 2);
        send_request(ltl_pkg::OP_POLL, '1, '1, 0);
        send_request(ltl_pkg::OP_TICK, 12'hAAA, 24'h555555, 0);
        send_request(ltl_pkg::OP_POLL, 12'h555, 24'hAAAAAA, 0);
        send_request(ltl_pkg::OP_TICK, '0, '0, 0);
        send_request(ltl_pkg::OP_POLL, '0, '0, 0);
        send_request(ltl_pkg::OP_POLL, '0, '0, 0);
        send_request(ltl_pkg::OP_TICK, '0, '0, 0);
        send_request(ltl_pkg::OP_POLL, '0, '0, 0);
        send_request(ltl_pkg::OP_POLL, '0, '0, 0);
        send_request(ltl_pkg::OP_ARM, 12'd7, 24'h800000, 0);
        send_request(ltl_pkg::OP_POLL, '0, '0, 3);

        // Random: a calm stretch, then stalls on both sides.
        random_phase(200, 1'b1);
        random_phase(1700, 1'b0);
        s_axis_tvalid <= 1'b0;

        while (board.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("%0d requests sent, %0d results checked, %0d ids still linked",
            sent, got, board.order.size());
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

>>> sim.f
+incdir+sv
sv/ltl_pkg.sv
sv/ltl_front.sv
sv/ltl_fifo.sv
sv/ltl_back.sv
sv/lru_idle_timeout_list.sv
sv/ltl_checker.sv
sim/tb_lru_idle_timeout_list.sv
